>>> rtl/rpmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpmc_pkg;

    // grid geometry, fixed by the coordinate fields
    localparam int COORD_W = 5;
    localparam int GRID_W  = 32;
    localparam int GRID_H  = 32;
    localparam int CELL_AW = 2 * COORD_W;
    localparam int CELL_N  = GRID_W * GRID_H;
    localparam int RAND_W  = 16;

    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_STEP  = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;

    localparam logic [2:0] LINK_NONE = 3'd4;

    typedef enum logic [1:0] {
        CS_BLOCKED  = 2'd0,
        CS_PASSAGE  = 2'd1,
        CS_FRONTIER = 2'd2
    } t_cell;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef struct packed {
        logic [1:0]        func;
        logic [4:0]        x;
        logic [4:0]        y;
        logic [RAND_W-1:0] rand_pick;
        logic [RAND_W-1:0] rand_dir;
    } t_in_beat;

    typedef struct packed {
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic       carved;
        logic [2:0] link_dir;
        logic [1:0] cell_state;
        logic [8:0] frontier_count;
        logic       done_res;
    } t_out_beat;

    typedef struct packed {
        logic               ok;
        logic [CELL_AW-1:0] addr;
    } t_nb;

    // neighbour one or two cells away, with its grid check
    function automatic t_nb nb_pos(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                   t_dir d, logic far);
        logic signed [COORD_W+1:0] nx;
        logic signed [COORD_W+1:0] ny;
        logic signed [COORD_W+1:0] st;
        t_nb r;
        st = far ? (COORD_W+2)'(2) : (COORD_W+2)'(1);
        nx = signed'({2'b00, cx});
        ny = signed'({2'b00, cy});
        unique case (d)
            DIR_LEFT:  nx = nx - st;
            DIR_UP:    ny = ny - st;
            DIR_RIGHT: nx = nx + st;
            DIR_DOWN:  ny = ny + st;
            default:   nx = nx;
        endcase
        r.ok   = (nx >= 0) && (ny >= 0) && (int'(nx) < GRID_W) && (int'(ny) < GRID_H);
        // row-major index, grid width a power of two
        r.addr = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/rpmc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface rpmc_in_if;
    logic               valid;
    logic               ready;
    rpmc_pkg::t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rpmc_out_if;
    logic                valid;
    logic                ready;
    rpmc_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/rpmc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rpmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/rpmc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rpmc_div #(
    parameter int DIV_W = 9
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rpmc_pkg::RAND_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]            i_divisor,
    output logic                             o_done,
    output logic      [DIV_W-1:0]            o_rem
);
    import rpmc_pkg::*;

    localparam int CNT_W = $clog2(RAND_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [RAND_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W:0]   t_trial;

    assign t_trial = {r_rem, r_dvd[RAND_W-1]};
    assign o_rem   = r_rem;

    // restoring remainder, one dividend bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (t_trial >= {1'b0, r_div}) begin
                    r_rem <= DIV_W'(t_trial - {1'b0, r_div});
                end else begin
                    r_rem <= t_trial[DIV_W-1:0];
                end
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RAND_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/random_prim_maze_carver_core.sv
`timescale 1ns / 1ps
`default_nettype none
// one item at a time; the next is taken once the result is in the output register
// read: a registered cell memory read; start: a sweep clearing all 1024 cells, then the seed scan
// step: a remainder pass picks the entry, the entries behind it shift through one memory port,
//   then the neighbour scan runs, and a second remainder pass picks the wall when one opens
// reset: a clearing pass over all 1024 cells of the cell memory, no beat accepted meanwhile;
//   afterwards the frontier is empty and the finished flag is set
module random_prim_maze_carver_core #(
    parameter int FRONTIER_DEPTH = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rpmc_in_if.sink    i_in,
    rpmc_out_if.source o_out
);
    import rpmc_pkg::*;

    localparam int IDX_W = $clog2(FRONTIER_DEPTH);
    localparam int CNT_W = $clog2(FRONTIER_DEPTH + 1);

    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_RDW   = 14'b00000000000100,
        S_SEED  = 14'b00000000001000,
        S_DIV   = 14'b00000000010000,
        S_FRD   = 14'b00000000100000,
        S_FWT   = 14'b00000001000000,
        S_SHRD  = 14'b00000010000000,
        S_SHWR  = 14'b00000100000000,
        S_NBRD  = 14'b00001000000000,
        S_NBCHK = 14'b00010000000000,
        S_LDIV  = 14'b00100000000000,
        S_LINK  = 14'b01000000000000,
        S_CARVE = 14'b10000000000000
    } t_state;

    t_state             r_state;
    logic               r_resp;
    logic [CELL_AW-1:0] r_clr;
    logic [CNT_W-1:0]   r_size;
    logic               r_fin;
    t_in_beat           r_in;
    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic [IDX_W-1:0]   r_i;
    t_dir               r_d;
    logic               r_step;
    logic [3:0]         r_cand;
    logic [2:0]         r_link;
    logic               r_carved;
    logic [1:0]         r_cst;
    logic               r_ov;
    t_out_beat          r_out;

    logic               c_we;
    logic [CELL_AW-1:0] c_waddr;
    logic [1:0]         c_wdata;
    logic [CELL_AW-1:0] c_raddr;
    logic [1:0]         c_rd;
    logic               f_we;
    logic [IDX_W-1:0]   f_waddr;
    logic [CELL_AW-1:0] f_wdata;
    logic [IDX_W-1:0]   f_raddr;
    logic [CELL_AW-1:0] f_rd;

    logic               div_start;
    logic [CNT_W-1:0]   div_divisor;
    logic [RAND_W-1:0]  div_dividend;
    logic               div_done;
    logic [CNT_W-1:0]   div_rem;

    t_nb                nb;
    t_nb                wall;
    logic               add_ok;
    logic [3:0]         n_cand;
    logic [2:0]         cand_n;
    logic               loop_end;
    logic               in_acc;
    logic [1:0]         sel_dir;

    assign nb     = nb_pos(r_cx, r_cy, r_d, 1'b1);
    assign wall   = nb_pos(r_cx, r_cy, t_dir'(r_link[1:0]), 1'b0);
    assign add_ok = (r_state == S_NBCHK) && (c_rd == CS_BLOCKED)
                    && (int'(r_size) < FRONTIER_DEPTH);
    assign in_acc = i_in.valid && i_in.ready;

    assign i_in.ready  = (r_state == S_IDLE) && !r_resp;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // candidate directions with a passage two cells away
    always_comb begin
        n_cand = r_cand;
        if (r_state == S_NBCHK && c_rd == CS_PASSAGE) begin
            n_cand[r_d] = 1'b1;
        end
        cand_n = 3'(n_cand[0]) + 3'(n_cand[1]) + 3'(n_cand[2]) + 3'(n_cand[3]);
    end

    assign loop_end = ((r_state == S_NBRD && !nb.ok) || r_state == S_NBCHK)
                      && (r_d == DIR_DOWN);

    // pick the chosen candidate by its rank
    always_comb begin
        logic [1:0] k;
        k       = '0;
        sel_dir = '0;
        for (int d = 0; d < 4; d++) begin
            if (r_cand[d]) begin
                if (k == div_rem[1:0]) begin
                    sel_dir = 2'(d);
                end
                k = k + 1'b1;
            end
        end
    end

    // divider requests: entry pick, then direction pick
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_in.rand_dir;
        div_divisor  = CNT_W'(cand_n);
        if (r_state == S_IDLE && in_acc && i_in.data.func == FN_STEP && !r_fin
            && r_size != '0) begin
            div_start    = 1'b1;
            div_dividend = i_in.data.rand_pick;
            div_divisor  = r_size;
        end else if (loop_end && r_step && n_cand != '0) begin
            div_start = 1'b1;
        end
    end

    // cell memory port control
    always_comb begin
        c_we    = 1'b0;
        c_waddr = {r_cy, r_cx};
        c_wdata = CS_PASSAGE;
        c_raddr = nb.addr;
        unique case (r_state)
            S_CLR: begin
                c_we    = 1'b1;
                c_waddr = r_clr;
                c_wdata = CS_BLOCKED;
            end
            S_IDLE:  c_raddr = {i_in.data.y, i_in.data.x};
            S_SEED:  c_we = 1'b1;
            S_NBCHK: begin
                c_we    = add_ok;
                c_waddr = nb.addr;
                c_wdata = CS_FRONTIER;
            end
            S_LINK: begin
                c_we    = 1'b1;
                c_waddr = wall.addr;
            end
            S_CARVE: c_we = 1'b1;
            default: c_we = 1'b0;
        endcase
    end

    // frontier memory port control
    always_comb begin
        f_we    = 1'b0;
        f_waddr = r_size[IDX_W-1:0];
        f_wdata = nb.addr;
        f_raddr = r_i;
        if (add_ok) begin
            f_we = 1'b1;
        end else if (r_state == S_SHWR) begin
            f_we    = 1'b1;
            f_waddr = r_i;
            f_wdata = f_rd;
        end
        if (r_state == S_SHRD) begin
            f_raddr = IDX_W'(r_i + 1'b1);
        end
    end

    rpmc_ram #(.WIDTH(2), .DEPTH(CELL_N)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rd)
    );

    rpmc_ram #(.WIDTH(CELL_AW), .DEPTH(FRONTIER_DEPTH)) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rd)
    );

    rpmc_div #(.DIV_W(CNT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_resp  <= 1'b0;
            r_clr   <= '0;
            r_size  <= '0;
            r_fin   <= 1'b1;
            r_ov    <= 1'b0;
            r_step  <= 1'b1;
        end else begin
            // result beat into the output register
            if (r_resp && (!r_ov || o_out.ready)) begin
                r_resp               <= 1'b0;
                r_ov                 <= 1'b1;
                r_out.cell_x         <= r_carved ? r_cx : '0;
                r_out.cell_y         <= r_carved ? r_cy : '0;
                r_out.carved         <= r_carved;
                r_out.link_dir       <= r_link;
                r_out.cell_state     <= r_cst;
                r_out.frontier_count <= 9'(r_size);
                r_out.done_res       <= r_fin;
            end else if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CELL_AW'(CELL_N - 1)) begin
                        r_state <= r_step ? S_IDLE : S_SEED;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_in     <= i_in.data;
                        r_cx     <= i_in.data.x;
                        r_cy     <= i_in.data.y;
                        r_carved <= 1'b0;
                        r_link   <= LINK_NONE;
                        r_cst    <= CS_BLOCKED;
                        if (i_in.data.func == FN_START) begin
                            r_size  <= '0;
                            r_fin   <= 1'b0;
                            r_step  <= 1'b0;
                            r_state <= S_CLR;
                        end else if (i_in.data.func == FN_STEP) begin
                            if (r_fin) begin
                                r_resp <= 1'b1;
                            end else if (r_size == '0) begin
                                r_fin  <= 1'b1;
                                r_resp <= 1'b1;
                            end else begin
                                r_step  <= 1'b1;
                                r_state <= S_DIV;
                            end
                        end else if (i_in.data.func == FN_READ) begin
                            r_state <= S_RDW;
                        end else begin
                            r_resp <= 1'b1;
                        end
                    end
                end
                S_RDW: begin
                    r_cst   <= c_rd;
                    r_resp  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SEED: begin
                    r_d     <= DIR_LEFT;
                    r_cand  <= '0;
                    r_state <= S_NBRD;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_i     <= div_rem[IDX_W-1:0];
                        r_state <= S_FRD;
                    end
                end
                S_FRD: r_state <= S_FWT;
                S_FWT: begin
                    r_cx    <= f_rd[COORD_W-1:0];
                    r_cy    <= f_rd[CELL_AW-1:COORD_W];
                    r_state <= S_SHRD;
                end
                S_SHRD: begin
                    if (CNT_W'(r_i) + 1'b1 < r_size) begin
                        r_state <= S_SHWR;
                    end else begin
                        r_size  <= r_size - 1'b1;
                        r_d     <= DIR_LEFT;
                        r_cand  <= '0;
                        r_state <= S_NBRD;
                    end
                end
                S_SHWR: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SHRD;
                end
                S_NBRD, S_NBCHK: begin
                    if (add_ok) begin
                        r_size <= r_size + 1'b1;
                    end
                    r_cand <= n_cand;
                    if (r_state == S_NBRD && nb.ok) begin
                        r_state <= S_NBCHK;
                    end else if (loop_end) begin
                        if (!r_step) begin
                            r_resp  <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (n_cand != '0) begin
                            r_state <= S_LDIV;
                        end else begin
                            r_state <= S_CARVE;
                        end
                    end else begin
                        r_d     <= t_dir'(r_d + 1'b1);
                        r_state <= S_NBRD;
                    end
                end
                S_LDIV: begin
                    if (div_done) begin
                        r_link  <= {1'b0, sel_dir};
                        r_state <= S_LINK;
                    end
                end
                S_LINK: r_state <= S_CARVE;
                S_CARVE: begin
                    r_carved <= 1'b1;
                    r_resp   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // frontier never overfills its memory
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_size) <= FRONTIER_DEPTH)
        else $error("frontier count beyond depth");

    // a remainder only arrives while the sequencer waits for one
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV || r_state == S_LDIV))
        else $error("divider result outside a wait state");

    // no wall is reported unless a cell was carved
    a_link_carve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.carved) |-> (r_out.link_dir == LINK_NONE))
        else $error("link direction without a carved cell");

    // an accepted step beat with a non-empty frontier, not yet finished, leaves idle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !(r_state == S_IDLE && !r_resp && !$past(i_in.data.func == FN_READ)
                     && $past(i_in.data.func == FN_STEP) && $past(r_size != '0)
                     && !$past(r_fin)))
        else $error("step beat did not leave idle");
`endif
endmodule
`default_nettype wire
